[rtl/sha_pkg.sv]
package sha_pkg;

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c62, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0a3b, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word a, b, c, d, e, f, g, h;
    } t_vars;

    function automatic t_word ror32(input t_word x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[rtl/sha_round.sv]
module sha_round
    import sha_pkg::*;
(
    input  t_vars i_v,
    input  t_word i_k,
    input  t_word i_w,
    output t_vars o_v
);
    t_word big1, choose, tmp1, big0, major;

    always_comb begin
        big1   = ror32(i_v.e, 6) ^ ror32(i_v.e, 11) ^ ror32(i_v.e, 25);
        choose = (i_v.e & i_v.f) ^ (~i_v.e & i_v.g);
        tmp1   = i_v.h + big1 + choose + i_k + i_w;
        big0   = ror32(i_v.a, 2) ^ ror32(i_v.a, 13) ^ ror32(i_v.a, 22);
        major  = (i_v.a & i_v.b) ^ (i_v.a & i_v.c) ^ (i_v.b & i_v.c);
        o_v.h  = i_v.g;
        o_v.g  = i_v.f;
        o_v.f  = i_v.e;
        o_v.e  = i_v.d + tmp1;
        o_v.d  = i_v.c;
        o_v.c  = i_v.b;
        o_v.b  = i_v.a;
        o_v.a  = tmp1 + big0 + major;
    end
endmodule

[rtl/sha256_stream_hasher.sv]
// SHA-256 over a byte stream. Each item carries an optional byte and an
// end-of-message flag. A byte that does not complete a 64-byte block is
// written to the block memory. A byte that completes a block starts a
// compression: a load reads the 64 block bytes into the schedule words, the
// rounds run through one shared round unit and a fold adds into the chaining
// words, and o_stall is high throughout. At end of message the padding is
// written one byte a cycle, one or two compressions follow, then the eight
// digest words leave one per cycle while i_stall is low, index 0 first,
// through an output register, and the hasher then returns to idle; the next
// message starts from the initial hash values. No new byte is accepted while
// a compression runs.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FOLD, S_OUT
    } t_state;

    t_state      r_state;
    logic [7:0]  r_mem [64];
    logic [7:0]  r_rd;
    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic        r_end;
    logic        r_final;
    logic [5:0]  r_pos;
    logic [6:0]  r_cnt;
    t_word       r_chain [8];
    t_word       r_w [16];
    t_vars       r_v;
    t_vars       n_v;
    logic [3:0]  r_oidx;

    logic        acc;
    logic [5:0]  wr_addr, rd_addr;
    logic [7:0]  wr_data;
    logic        wr_en;
    logic [63:0] bit_len;
    logic [5:0]  fill_nx;
    t_word       w_cur, s0, s1, w_new;

    assign acc     = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign bit_len = r_len << 3;
    assign fill_nx = r_fill + 6'(i_byte_valid);

    // schedule: r_w[0] is word t
    assign w_cur = r_w[0];
    assign s0 = ror32(r_w[1], 7) ^ ror32(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1 = ror32(r_w[14], 17) ^ ror32(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_new = r_w[0] + s0 + r_w[9] + s1;

    sha_round u_round (
        .i_v (r_v),
        .i_k (K_ROUND[r_cnt[5:0]]),
        .i_w (w_cur),
        .o_v (n_v)
    );

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_fill;
        wr_data = i_data_byte;
        if (r_state == S_IDLE && acc && i_byte_valid) begin
            wr_en = 1'b1;
        end else if (r_state == S_PAD) begin
            wr_en   = 1'b1;
            wr_addr = r_pos;
            if (r_final && r_pos >= LENGTH_POS) begin
                wr_data = bit_len[{3'd7 - r_pos[2:0], 3'b000} +: 8];
            end else if (r_pos == r_fill && (!r_final || r_fill < LENGTH_POS)) begin
                wr_data = PAD_BYTE;
            end else begin
                wr_data = 8'h00;
            end
        end
        rd_addr = r_cnt[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_len   <= '0;
            r_end   <= 1'b0;
            r_final <= 1'b0;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_oidx  <= '0;
            o_valid <= 1'b0;
            for (int i = 0; i < 8; i++) r_chain[i] <= H_INIT[i];
        end else begin
            if (o_valid && !i_stall && !(r_state == S_OUT && r_oidx != 4'd8))
                o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_end   <= i_end_of_message;
                        r_cnt   <= '0;
                        if (i_byte_valid) begin
                            r_fill <= fill_nx;
                            r_len  <= r_len + 64'd1;
                        end
                        if (i_byte_valid && r_fill == 6'd63) begin
                            r_final <= 1'b0;
                            r_state <= S_LOAD;
                        end else if (i_end_of_message) begin
                            r_pos   <= fill_nx;
                            r_final <= (fill_nx < LENGTH_POS);
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    // pad byte at r_fill, then zeros, length in the final block
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) begin
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // memory read is registered; 64 reads pack 16 words
                    if (r_cnt != 7'd0) begin
                        if (r_cnt[1:0] == 2'd1) begin
                            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                            r_w[15] <= {24'h0, r_rd};
                        end else begin
                            r_w[15] <= {r_w[15][23:0], r_rd};
                        end
                    end
                    if (r_cnt == 7'd64) begin
                        r_cnt   <= '0;
                        r_state <= S_ROUND;
                        r_v <= '{r_chain[0], r_chain[1], r_chain[2], r_chain[3],
                                 r_chain[4], r_chain[5], r_chain[6], r_chain[7]};
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_ROUND: begin
                    r_v <= n_v;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    r_w[15] <= w_new;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_chain[0] <= r_chain[0] + r_v.a;
                    r_chain[1] <= r_chain[1] + r_v.b;
                    r_chain[2] <= r_chain[2] + r_v.c;
                    r_chain[3] <= r_chain[3] + r_v.d;
                    r_chain[4] <= r_chain[4] + r_v.e;
                    r_chain[5] <= r_chain[5] + r_v.f;
                    r_chain[6] <= r_chain[6] + r_v.g;
                    r_chain[7] <= r_chain[7] + r_v.h;
                    r_cnt <= '0;
                    if (r_final) begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end else if (r_end) begin
                        // block boundary reached by data or pad overflow
                        r_pos   <= '0;
                        r_final <= 1'b1;
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        if (r_oidx == 4'd8) begin
                            r_state <= S_IDLE;
                            r_fill  <= '0;
                            r_len   <= '0;
                            r_end   <= 1'b0;
                            r_final <= 1'b0;
                            for (int i = 0; i < 8; i++) r_chain[i] <= H_INIT[i];
                        end else begin
                            o_valid       <= 1'b1;
                            o_digest_word <= r_chain[r_oidx[2:0]];
                            o_word_index  <= r_oidx[2:0];
                            o_last_word   <= (r_oidx == 4'd7);
                            r_oidx        <= r_oidx + 4'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
